// ===== hw/rtl/mips64_integer_execute_macros.svh =====
// ----------------------------------------------------------------------------
// MIPS64 integer execute assertion macros
// Shared concurrent assertion forms for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef MIPS64_INTEGER_EXECUTE_MACROS_SVH
`define MIPS64_INTEGER_EXECUTE_MACROS_SVH

// check a property on every rising clock edge outside reset
`define MIE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every rising clock edge, reset included
`define MIE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/mie_pkg.sv =====
// ----------------------------------------------------------------------------
// MIPS64 integer execute package
// Opcode, function and exception codes, state type and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mie_pkg;

   localparam int DATA_WIDTH = 64;
   localparam int REG_COUNT  = 32;
   localparam int REG_IDX_W  = $clog2(REG_COUNT);
   localparam int RSP_DATA_W = 144;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_REGIMM  = 6'h01;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_SLTIU   = 6'h0B;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_XORI    = 6'h0E;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_BEQL    = 6'h14;
   localparam logic [5:0] OP_BNEL    = 6'h15;
   localparam logic [5:0] OP_BLEZL   = 6'h16;
   localparam logic [5:0] OP_BGTZL   = 6'h17;

   localparam logic [5:0] FN_SLL     = 6'h00;
   localparam logic [5:0] FN_SRL     = 6'h02;
   localparam logic [5:0] FN_SRA     = 6'h03;
   localparam logic [5:0] FN_SLLV    = 6'h04;
   localparam logic [5:0] FN_SRLV    = 6'h06;
   localparam logic [5:0] FN_SRAV    = 6'h07;
   localparam logic [5:0] FN_JR      = 6'h08;
   localparam logic [5:0] FN_JALR    = 6'h09;
   localparam logic [5:0] FN_SYSCALL = 6'h0C;
   localparam logic [5:0] FN_MFHI    = 6'h10;
   localparam logic [5:0] FN_MTHI    = 6'h11;
   localparam logic [5:0] FN_MFLO    = 6'h12;
   localparam logic [5:0] FN_MTLO    = 6'h13;
   localparam logic [5:0] FN_MULT    = 6'h18;
   localparam logic [5:0] FN_MULTU   = 6'h19;
   localparam logic [5:0] FN_DIV     = 6'h1A;
   localparam logic [5:0] FN_DIVU    = 6'h1B;
   localparam logic [5:0] FN_ADD     = 6'h20;
   localparam logic [5:0] FN_ADDU    = 6'h21;
   localparam logic [5:0] FN_SUB     = 6'h22;
   localparam logic [5:0] FN_SUBU    = 6'h23;
   localparam logic [5:0] FN_AND     = 6'h24;
   localparam logic [5:0] FN_OR      = 6'h25;
   localparam logic [5:0] FN_XOR     = 6'h26;
   localparam logic [5:0] FN_NOR     = 6'h27;
   localparam logic [5:0] FN_SLT     = 6'h2A;
   localparam logic [5:0] FN_SLTU    = 6'h2B;

   localparam logic [4:0] RT_BLTZ    = 5'h00;
   localparam logic [4:0] RT_BGEZ    = 5'h01;
   localparam logic [4:0] RT_BLTZL   = 5'h02;
   localparam logic [4:0] RT_BGEZL   = 5'h03;
   localparam logic [4:0] RT_BLTZAL  = 5'h10;
   localparam logic [4:0] RT_BGEZAL  = 5'h11;
   localparam logic [4:0] RT_BLTZALL = 5'h12;
   localparam logic [4:0] RT_BGEZALL = 5'h13;

   localparam logic [4:0] LINK_REG   = 5'd31;

   typedef enum logic [1:0] {
      EXC_NONE = 2'd0,
      EXC_OVF  = 2'd1,
      EXC_SYS  = 2'd2,
      EXC_RI   = 2'd3
   } exc_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_READ = 7'b0000010,
      ST_EXEC = 7'b0000100,
      ST_MUL  = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_DFIN = 7'b0100000,
      ST_RESP = 7'b1000000
   } state_type;

   function automatic logic [DATA_WIDTH-1:0] sx32(input logic [31:0] v);
      return {{(DATA_WIDTH-32){v[31]}}, v};
   endfunction

endpackage

// ===== hw/rtl/mips64_integer_execute.sv =====
// ----------------------------------------------------------------------------
// MIPS64 integer execute unit
// Executes one MIPS III integer instruction per request on a 64-bit
// register file, with HI/LO, delay-slot branches and an iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one 32-bit instruction word per request, fetched at the current
//            program counter.
//   rsp_*  : one result per request: next fetch address, register write,
//            nullify flag and exception code.
//   csr_*  : writes the 32-bit start address; it is sign-extended and loads
//            the program counter and clears any pending branch.
//   rsp_tvalid rises after the register read and execute states;
//   MULT/MULTU add a multiply state, and DIV/DIVU add the divide and
//   finish states of the one-bit-per-cycle restoring divider (skipped on
//   a zero divisor).
//   A new request is taken only after the result is handed back and the
//   block has returned to idle.
//   req_tready is high only in idle; a stalled result holds rsp_tdata and
//   keeps the block busy until rsp_tready takes it.
//   Reset clears all registers, HI, LO and the pending branch, and sets the
//   program counter to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mips64_integer_execute (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,   // instr_word
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // next_pc, reg_write, reg_index, reg_value, nullify_next, exception_code
   output logic [mie_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [31:0]                     csr_data
);

   localparam int DW = mie_pkg::DATA_WIDTH;
   localparam int IW = mie_pkg::REG_IDX_W;

   mie_pkg::state_type state_ff, state_in;

   logic [31:0]    instr_ff;
   logic [DW-1:0]  pc_ff, btarget_ff, hi_ff, lo_ff;
   logic           pend_ff;
   logic [DW-1:0]  gpr_mem [mie_pkg::REG_COUNT];
   logic [mie_pkg::REG_COUNT-1:0] gpr_vld_ff;
   logic [DW-1:0]  rda_ff, rdb_ff;
   logic           vlda_ff, vldb_ff;
   logic [DW-1:0]  seq_ff, link_ff, brt_ff;

   logic [DW-1:0]  rsp_pc_ff, rsp_val_ff;
   logic           rsp_we_ff, rsp_nul_ff;
   logic [IW-1:0]  rsp_idx_ff;
   logic [1:0]     rsp_exc_ff;

   logic [DW-1:0]  mul_ff;
   logic [31:0]    quo_ff, rem_ff, den_ff;
   logic           qneg_ff, rneg_ff;
   logic [4:0]     cnt_ff;

   logic [5:0]     op, fn;
   logic [4:0]     rs, rt, rd, sh, amt;
   logic [15:0]    imm;
   logic [DW-1:0]  a, b, simm, zimm, op2, opb, sum;
   logic           cout, sub, ltu, lts, ovf, cond;
   logic [31:0]    sll_r, srl_r, sra_r;
   logic [DW+1:0]  prod;

   logic           ex_we, ex_taken, ex_nul, ex_mul, ex_div, ex_hi_we, ex_lo_we, wr_en;
   logic [IW-1:0]  ex_idx;
   logic [DW-1:0]  ex_val, ex_tgt, ex_hi, ex_lo;
   logic [1:0]     ex_exc;

   logic [32:0]    rem_sh, diff;
   logic [31:0]    num_abs, den_abs;

   assign op  = instr_ff[31:26];
   assign rs  = instr_ff[25:21];
   assign rt  = instr_ff[20:16];
   assign rd  = instr_ff[15:11];
   assign sh  = instr_ff[10:6];
   assign fn  = instr_ff[5:0];
   assign imm = instr_ff[15:0];

   assign a    = vlda_ff ? rda_ff : '0;
   assign b    = vldb_ff ? rdb_ff : '0;
   assign simm = {{(DW-16){imm[15]}}, imm};
   assign zimm = {{(DW-16){1'b0}}, imm};

   assign sub = (op == mie_pkg::OP_SPECIAL &&
                 (fn == mie_pkg::FN_SUB || fn == mie_pkg::FN_SUBU ||
                  fn == mie_pkg::FN_SLT || fn == mie_pkg::FN_SLTU)) ||
                op == mie_pkg::OP_SLTI || op == mie_pkg::OP_SLTIU;
   assign op2 = (op == mie_pkg::OP_SPECIAL) ? b : simm;
   assign opb = sub ? ~op2 : op2;
   assign {cout, sum} = {1'b0, a} + {1'b0, opb} + {{DW{1'b0}}, sub};
   assign ltu = ~cout;
   assign lts = (a[DW-1] ^ op2[DW-1]) ? a[DW-1] : sum[DW-1];
   assign ovf = ~(a[31] ^ opb[31]) & (a[31] ^ sum[31]);

   assign amt   = fn[2] ? a[4:0] : sh;
   assign sll_r = b[31:0] << amt;
   assign srl_r = b[31:0] >> amt;
   assign sra_r = $unsigned($signed(b[31:0]) >>> amt);

   assign prod = $signed({(fn == mie_pkg::FN_MULT) & a[31], a[31:0]}) *
                 $signed({(fn == mie_pkg::FN_MULT) & b[31], b[31:0]});

   assign num_abs = (fn == mie_pkg::FN_DIV && a[31]) ? (32'd0 - a[31:0]) : a[31:0];
   assign den_abs = (fn == mie_pkg::FN_DIV && b[31]) ? (32'd0 - b[31:0]) : b[31:0];

   assign rem_sh = {rem_ff, quo_ff[31]};
   assign diff   = rem_sh - {1'b0, den_ff};

   always_comb begin
      ex_we    = 1'b0;
      ex_idx   = rd;
      ex_val   = '0;
      ex_taken = 1'b0;
      ex_tgt   = '0;
      ex_nul   = 1'b0;
      ex_exc   = mie_pkg::EXC_NONE;
      ex_mul   = 1'b0;
      ex_div   = 1'b0;
      ex_hi_we = 1'b0;
      ex_lo_we = 1'b0;
      ex_hi    = a;
      ex_lo    = a;
      cond     = 1'b0;
      case (op)
         mie_pkg::OP_SPECIAL: begin
            case (fn)
               mie_pkg::FN_SLL, mie_pkg::FN_SLLV: begin
                  ex_we = 1'b1; ex_val = mie_pkg::sx32(sll_r);
               end
               mie_pkg::FN_SRL, mie_pkg::FN_SRLV: begin
                  ex_we = 1'b1; ex_val = mie_pkg::sx32(srl_r);
               end
               mie_pkg::FN_SRA, mie_pkg::FN_SRAV: begin
                  ex_we = 1'b1; ex_val = mie_pkg::sx32(sra_r);
               end
               mie_pkg::FN_JR: begin
                  ex_taken = 1'b1; ex_tgt = a;
               end
               mie_pkg::FN_JALR: begin
                  ex_taken = 1'b1; ex_tgt = a; ex_we = 1'b1; ex_val = link_ff;
               end
               mie_pkg::FN_SYSCALL: ex_exc = mie_pkg::EXC_SYS;
               mie_pkg::FN_MFHI: begin
                  ex_we = 1'b1; ex_val = hi_ff;
               end
               mie_pkg::FN_MTHI: ex_hi_we = 1'b1;
               mie_pkg::FN_MFLO: begin
                  ex_we = 1'b1; ex_val = lo_ff;
               end
               mie_pkg::FN_MTLO: ex_lo_we = 1'b1;
               mie_pkg::FN_MULT, mie_pkg::FN_MULTU: ex_mul = 1'b1;
               mie_pkg::FN_DIV, mie_pkg::FN_DIVU: begin
                  if (b[31:0] == 32'd0) begin
                     ex_hi_we = 1'b1;
                     ex_lo_we = 1'b1;
                     ex_hi    = mie_pkg::sx32(a[31:0]);
                     ex_lo    = '1;
                  end else begin
                     ex_div = 1'b1;
                  end
               end
               mie_pkg::FN_ADD, mie_pkg::FN_SUB: begin
                  if (ovf) begin
                     ex_exc = mie_pkg::EXC_OVF;
                  end else begin
                     ex_we = 1'b1; ex_val = mie_pkg::sx32(sum[31:0]);
                  end
               end
               mie_pkg::FN_ADDU, mie_pkg::FN_SUBU: begin
                  ex_we = 1'b1; ex_val = mie_pkg::sx32(sum[31:0]);
               end
               mie_pkg::FN_AND: begin
                  ex_we = 1'b1; ex_val = a & b;
               end
               mie_pkg::FN_OR: begin
                  ex_we = 1'b1; ex_val = a | b;
               end
               mie_pkg::FN_XOR: begin
                  ex_we = 1'b1; ex_val = a ^ b;
               end
               mie_pkg::FN_NOR: begin
                  ex_we = 1'b1; ex_val = ~(a | b);
               end
               mie_pkg::FN_SLT: begin
                  ex_we = 1'b1; ex_val = {{(DW-1){1'b0}}, lts};
               end
               mie_pkg::FN_SLTU: begin
                  ex_we = 1'b1; ex_val = {{(DW-1){1'b0}}, ltu};
               end
               default: ex_exc = mie_pkg::EXC_RI;
            endcase
         end
         mie_pkg::OP_REGIMM: begin
            case (rt)
               mie_pkg::RT_BLTZ, mie_pkg::RT_BGEZ, mie_pkg::RT_BLTZL,
               mie_pkg::RT_BGEZL, mie_pkg::RT_BLTZAL, mie_pkg::RT_BGEZAL,
               mie_pkg::RT_BLTZALL, mie_pkg::RT_BGEZALL: begin
                  cond = a[DW-1] ^ rt[0];
                  if (rt[4]) begin
                     ex_we = 1'b1; ex_idx = mie_pkg::LINK_REG; ex_val = link_ff;
                  end
                  ex_taken = cond;
                  ex_tgt   = brt_ff;
                  ex_nul   = ~cond & rt[1];
               end
               default: ex_exc = mie_pkg::EXC_RI;
            endcase
         end
         mie_pkg::OP_J, mie_pkg::OP_JAL: begin
            ex_taken = 1'b1;
            ex_tgt   = {seq_ff[DW-1:28], instr_ff[25:0], 2'b00};
            if (op == mie_pkg::OP_JAL) begin
               ex_we = 1'b1; ex_idx = mie_pkg::LINK_REG; ex_val = link_ff;
            end
         end
         mie_pkg::OP_BEQ, mie_pkg::OP_BNE, mie_pkg::OP_BLEZ, mie_pkg::OP_BGTZ,
         mie_pkg::OP_BEQL, mie_pkg::OP_BNEL, mie_pkg::OP_BLEZL, mie_pkg::OP_BGTZL: begin
            case (op[1:0])
               2'd0:    cond = (a == b);
               2'd1:    cond = (a != b);
               2'd2:    cond = a[DW-1] | (a == '0);
               default: cond = ~a[DW-1] & (a != '0);
            endcase
            ex_taken = cond;
            ex_tgt   = brt_ff;
            ex_nul   = ~cond & op[4];
         end
         mie_pkg::OP_ADDI: begin
            ex_idx = rt;
            if (ovf) begin
               ex_exc = mie_pkg::EXC_OVF;
            end else begin
               ex_we = 1'b1; ex_val = mie_pkg::sx32(sum[31:0]);
            end
         end
         mie_pkg::OP_ADDIU: begin
            ex_idx = rt; ex_we = 1'b1; ex_val = mie_pkg::sx32(sum[31:0]);
         end
         mie_pkg::OP_SLTI: begin
            ex_idx = rt; ex_we = 1'b1; ex_val = {{(DW-1){1'b0}}, lts};
         end
         mie_pkg::OP_SLTIU: begin
            ex_idx = rt; ex_we = 1'b1; ex_val = {{(DW-1){1'b0}}, ltu};
         end
         mie_pkg::OP_ANDI: begin
            ex_idx = rt; ex_we = 1'b1; ex_val = a & zimm;
         end
         mie_pkg::OP_ORI: begin
            ex_idx = rt; ex_we = 1'b1; ex_val = a | zimm;
         end
         mie_pkg::OP_XORI: begin
            ex_idx = rt; ex_we = 1'b1; ex_val = a ^ zimm;
         end
         mie_pkg::OP_LUI: begin
            ex_idx = rt; ex_we = 1'b1; ex_val = mie_pkg::sx32({imm, 16'd0});
         end
         default: ex_exc = mie_pkg::EXC_RI;
      endcase
   end

   assign wr_en = ex_we && (ex_idx != '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mie_pkg::ST_IDLE: if (req_tvalid) state_in = mie_pkg::ST_READ;
         mie_pkg::ST_READ: state_in = mie_pkg::ST_EXEC;
         mie_pkg::ST_EXEC: begin
            if (ex_mul)      state_in = mie_pkg::ST_MUL;
            else if (ex_div) state_in = mie_pkg::ST_DIV;
            else             state_in = mie_pkg::ST_RESP;
         end
         mie_pkg::ST_MUL:  state_in = mie_pkg::ST_RESP;
         mie_pkg::ST_DIV:  if (cnt_ff == '1) state_in = mie_pkg::ST_DFIN;
         mie_pkg::ST_DFIN: state_in = mie_pkg::ST_RESP;
         mie_pkg::ST_RESP: if (rsp_tready) state_in = mie_pkg::ST_IDLE;
         default:          state_in = mie_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mie_pkg::ST_IDLE;
         pc_ff      <= '0;
         pend_ff    <= 1'b0;
         btarget_ff <= '0;
         hi_ff      <= '0;
         lo_ff      <= '0;
         gpr_vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            pc_ff   <= mie_pkg::sx32(csr_data);
            pend_ff <= 1'b0;
         end
         if (state_ff == mie_pkg::ST_EXEC) begin
            pc_ff      <= pend_ff ? btarget_ff : (ex_nul ? link_ff : seq_ff);
            pend_ff    <= ex_taken;
            btarget_ff <= ex_taken ? ex_tgt : '0;
            if (ex_hi_we) hi_ff <= ex_hi;
            if (ex_lo_we) lo_ff <= ex_lo;
            if (wr_en) gpr_vld_ff[ex_idx] <= 1'b1;
         end
         if (state_ff == mie_pkg::ST_MUL) begin
            hi_ff <= mie_pkg::sx32(mul_ff[63:32]);
            lo_ff <= mie_pkg::sx32(mul_ff[31:0]);
         end
         if (state_ff == mie_pkg::ST_DFIN) begin
            hi_ff <= mie_pkg::sx32(rneg_ff ? (32'd0 - rem_ff) : rem_ff);
            lo_ff <= mie_pkg::sx32(qneg_ff ? (32'd0 - quo_ff) : quo_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == mie_pkg::ST_EXEC && wr_en) gpr_mem[ex_idx] <= ex_val;
      if (state_ff == mie_pkg::ST_READ) begin
         rda_ff <= gpr_mem[rs];
         rdb_ff <= gpr_mem[rt];
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) instr_ff <= req_tdata;
      if (state_ff == mie_pkg::ST_READ) begin
         vlda_ff <= gpr_vld_ff[rs];
         vldb_ff <= gpr_vld_ff[rt];
         seq_ff  <= pc_ff + 64'd4;
         link_ff <= pc_ff + 64'd8;
         brt_ff  <= pc_ff + 64'd4 + {simm[DW-3:0], 2'b00};
      end
      if (state_ff == mie_pkg::ST_EXEC) begin
         rsp_pc_ff  <= pend_ff ? btarget_ff : (ex_nul ? link_ff : seq_ff);
         rsp_we_ff  <= wr_en;
         rsp_idx_ff <= wr_en ? ex_idx : '0;
         rsp_val_ff <= wr_en ? ex_val : '0;
         rsp_nul_ff <= ex_nul & ~pend_ff;
         rsp_exc_ff <= ex_exc;
         mul_ff     <= prod[DW-1:0];
         quo_ff     <= num_abs;
         rem_ff     <= '0;
         den_ff     <= den_abs;
         qneg_ff    <= (fn == mie_pkg::FN_DIV) & (a[31] ^ b[31]);
         rneg_ff    <= (fn == mie_pkg::FN_DIV) & a[31];
         cnt_ff     <= '0;
      end
      if (state_ff == mie_pkg::ST_DIV) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (!diff[32]) begin
            rem_ff <= diff[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[31:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

   assign req_tready = (state_ff == mie_pkg::ST_IDLE);
   assign csr_ready  = (state_ff == mie_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == mie_pkg::ST_RESP);
   assign rsp_tdata  = {7'd0, rsp_exc_ff, rsp_nul_ff, rsp_val_ff, rsp_idx_ff,
                        rsp_we_ff, rsp_pc_ff};

endmodule

// ===== hw/rtl/mie_checker.sv =====
// ----------------------------------------------------------------------------
// MIPS64 integer execute port checker
// Watches the top level's ports and checks handshake and result rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mips64_integer_execute_macros.svh"

module mie_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mie_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic req_fire;
   assign req_fire = req_tvalid & req_tready;

   `MIE_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   `MIE_ASSERT(a_busy_resp, clock, reset, rsp_tvalid |-> !req_tready, "request taken while response pending")
   `MIE_ASSERT(a_no_early_resp, clock, reset, req_fire |=> !rsp_tvalid, "response in cycle after request")
   `MIE_ASSERT(a_no_write_zero, clock, reset, rsp_tvalid && !rsp_tdata[64] |-> rsp_tdata[69:65] == 5'd0 && rsp_tdata[133:70] == 64'd0, "write fields set without write")
   `MIE_ASSERT(a_exc_no_write, clock, reset, rsp_tvalid && rsp_tdata[136:135] != mie_pkg::EXC_NONE |-> !rsp_tdata[64], "register written with exception")

endmodule

bind mips64_integer_execute mie_checker u_mie_checker (.*);
